/* rtl/core/pdh_pkg.sv */
// Shared types and codes for the pair distance histogram block.
// No dependencies; every other file in rtl/core imports this package.
package pdh_pkg;

	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [31:0] COUNT_SAT = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
	} atom_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] pos_z;
		logic        frame_end;
		logic [8:0]  bin_index;
	} in_t;

	typedef struct packed {
		logic [31:0] bin_count;
		logic [31:0] frames_seen;
	} out_t;

	typedef struct packed {
		logic clr_start;
		logic rd_en;
	} hist_ctrl_t;

	typedef struct packed {
		logic clr_busy;
		logic wr_busy;
	} hist_stat_t;

endpackage

/* rtl/core/pair_distance_histogram.sv */
// Pair distance histogram: an atom beat holds the input while the atom ring turns once
// (unless the store is empty) and then while the distance and square root pipeline
// and the histogram write drain, so no beat is taken before the last atom is through.
// A bin read passes through the read state; a clear runs the histogram sweep over all BINS.
// Reset clears the frame state and starts the same sweep, during which
// no beat is accepted. Depends on pdh_pkg, pdh_cell, pdh_pair and pdh_hist.
module pair_distance_histogram #(
	parameter int MAX_ATOMS = 128,
	parameter int BINS      = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pdh_pkg::in_t  in_beat,
	output logic          out_valid,
	input  logic          out_ready,
	output pdh_pkg::out_t out_beat
);
	import pdh_pkg::*;

	localparam int IDX_W = $clog2(MAX_ATOMS);
	localparam int CNT_W = $clog2(MAX_ATOMS + 1);
	localparam int BIN_W = $clog2(BINS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAIR,
		ST_DRAIN,
		ST_READ
	} state_t;

	state_t           state_q;
	atom_t            probe_q;
	logic             fend_q;
	logic [IDX_W-1:0] rot_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      frames_q;
	logic             rd_ok_q;
	out_t             out_q;
	logic             out_valid_q;

	atom_t            cell_q [MAX_ATOMS];
	logic             shift_en;
	logic             store_we;
	logic             accept;
	logic             pair_vld;
	logic             bin_vld;
	logic [BIN_W-1:0] bin;
	logic             pair_busy;
	hist_ctrl_t       hctrl;
	hist_stat_t       hstat;
	logic [31:0]      rd_data;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && !hstat.clr_busy &&
		!(in_beat.kind == KIND_READ && out_valid_q);
	assign shift_en = (state_q == ST_PAIR);
	assign pair_vld = (state_q == ST_PAIR) && (CNT_W'(rot_q) < count_q);
	assign store_we = (state_q == ST_DRAIN) && !pair_busy && !hstat.wr_busy &&
		(count_q < CNT_W'(MAX_ATOMS));

	assign hctrl.rd_en     = accept && (in_beat.kind == KIND_READ);
	assign hctrl.clr_start = accept && (in_beat.kind == KIND_CLEAR);

	// The ring turns towards cell 0, which feeds the pair pipeline.
	for (genvar i = 0; i < MAX_ATOMS; i++) begin : g_ring
		pdh_cell u_cell (
			.clk   (clk),
			.shift (shift_en),
			.load  (store_we && count_q == CNT_W'(i)),
			.nbr   (cell_q[(i + 1) % MAX_ATOMS]),
			.din   (probe_q),
			.q     (cell_q[i])
		);
	end

	pdh_pair #(.BINS(BINS), .BIN_W(BIN_W)) u_pair (
		.clk      (clk),
		.arst_n   (arst_n),
		.pair_vld (pair_vld),
		.probe    (probe_q),
		.other    (cell_q[0]),
		.bin_vld  (bin_vld),
		.bin      (bin),
		.busy     (pair_busy)
	);

	pdh_hist #(.BINS(BINS), .BIN_W(BIN_W)) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (hctrl),
		.rd_addr (BIN_W'(in_beat.bin_index)),
		.inc_vld (bin_vld),
		.inc_bin (bin),
		.rd_data (rd_data),
		.stat    (hstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rot_q       <= '0;
			count_q     <= '0;
			frames_q    <= '0;
			out_valid_q <= 1'b0;
			fend_q      <= 1'b0;
			rd_ok_q     <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_beat.kind)
							KIND_ADD: begin
								probe_q <= '{x: in_beat.pos_x, y: in_beat.pos_y,
									z: in_beat.pos_z};
								fend_q  <= in_beat.frame_end;
								rot_q   <= '0;
								state_q <= (count_q == '0) ? ST_DRAIN : ST_PAIR;
							end
							KIND_READ: begin
								rd_ok_q <= 32'(in_beat.bin_index) < BINS;
								state_q <= ST_READ;
							end
							KIND_CLEAR: begin
								frames_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PAIR: begin
					rot_q <= rot_q + 1'b1;
					if (rot_q == IDX_W'(MAX_ATOMS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pair_busy && !hstat.wr_busy) begin
						if (fend_q) begin
							count_q <= '0;
							if (frames_q != COUNT_SAT) begin
								frames_q <= frames_q + 32'd1;
							end
						end else if (count_q < CNT_W'(MAX_ATOMS)) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					out_q.bin_count   <= rd_ok_q ? rd_data : 32'd0;
					out_q.frames_seen <= frames_q;
					out_valid_q       <= 1'b1;
					state_q           <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

`ifndef SYNTHESIS
	a_read_needs_free_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_beat.kind == KIND_READ) |-> !out_valid_q)
		else $error("read accepted while a result is still held");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ATOMS))
		else $error("atom count beyond store depth");
	a_store_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		store_we |-> (!pair_busy && !hstat.wr_busy && !shift_en))
		else $error("atom stored while the ring or pipeline is busy");
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		hstat.clr_busy |-> !in_ready)
		else $error("beat accepted during histogram clear");
`endif

endmodule

/* rtl/core/pdh_cell.sv */
// One cell of the atom ring: holds a stored position and passes it on.
// Depends on pdh_pkg for the atom type.
module pdh_cell (
	input  logic          clk,
	input  logic          shift,
	input  logic          load,
	input  pdh_pkg::atom_t nbr,
	input  pdh_pkg::atom_t din,
	output pdh_pkg::atom_t q
);
	import pdh_pkg::*;

	atom_t atom_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			atom_q <= nbr;
		end else if (load) begin
			atom_q <= din;
		end
	end

	assign q = atom_q;

endmodule

/* rtl/core/pdh_pair.sv */
// Pair distance pipeline: minimum-image squared distance, pipelined
// square root and bin scaling. Depends on pdh_pkg.
module pdh_pair #(
	parameter int BINS  = 512,
	parameter int BIN_W = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pair_vld,
	input  pdh_pkg::atom_t      probe,
	input  pdh_pkg::atom_t      other,
	output logic                bin_vld,
	output logic [BIN_W-1:0]    bin,
	output logic                busy
);
	import pdh_pkg::*;

	localparam int SQ_STEPS = 15;

	logic [15:0] mag_x_s1, mag_y_s1, mag_z_s1;
	logic        vld_s1;
	logic [31:0] sq_x_s2, sq_y_s2, sq_z_s2;
	logic        vld_s2;
	logic [29:0] d2_s3;
	logic        vld_s3;
	logic [29:0] rem_sq  [SQ_STEPS+1];
	logic [29:0] root_sq [SQ_STEPS+1];
	logic        vld_sq  [SQ_STEPS+1];
	logic [BIN_W-1:0] bin_q;
	logic             bin_vld_q;
	logic [31:0]      d2_sum;
	logic [31:0]      prod;
	logic [SQ_STEPS-1:0] sq_busy;

	function automatic logic [15:0] axis_mag(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] d;
		d = a - b;
		return d[15] ? (~d + 16'd1) : d;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= pair_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2 && (d2_sum < 32'h4000_0000);
		end
	end

	assign d2_sum = sq_x_s2 + sq_y_s2 + sq_z_s2;

	always_ff @(posedge clk) begin
		mag_x_s1 <= axis_mag(probe.x, other.x);
		mag_y_s1 <= axis_mag(probe.y, other.y);
		mag_z_s1 <= axis_mag(probe.z, other.z);
		sq_x_s2  <= mag_x_s1 * mag_x_s1;
		sq_y_s2  <= mag_y_s1 * mag_y_s1;
		sq_z_s2  <= mag_z_s1 * mag_z_s1;
		d2_s3    <= d2_sum[29:0];
	end

	assign rem_sq[0]  = d2_s3;
	assign root_sq[0] = '0;
	assign vld_sq[0]  = vld_s3;

	// One digit of the square root per stage, highest digit first.
	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		localparam logic [29:0] STEP_BIT = 30'(1) << (28 - 2 * j);
		logic [30:0] trial;
		assign trial = {1'b0, root_sq[j]} + {1'b0, STEP_BIT};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sq[j+1] <= 1'b0;
			end else begin
				vld_sq[j+1] <= vld_sq[j];
			end
		end

		always_ff @(posedge clk) begin
			if ({1'b0, rem_sq[j]} >= trial) begin
				rem_sq[j+1]  <= rem_sq[j] - trial[29:0];
				root_sq[j+1] <= (root_sq[j] >> 1) + STEP_BIT;
			end else begin
				rem_sq[j+1]  <= rem_sq[j];
				root_sq[j+1] <= root_sq[j] >> 1;
			end
		end

		assign sq_busy[j] = vld_sq[j+1];
	end

	// The root is below 2^15, so root * BINS / 2^15 always lands inside the table.
	assign prod = 32'(root_sq[SQ_STEPS][14:0]) * 32'(BINS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= 1'b0;
		end else begin
			bin_vld_q <= vld_sq[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		bin_q <= prod[15 +: BIN_W];
	end

	assign bin_vld = bin_vld_q;
	assign bin     = bin_q;
	assign busy    = vld_s1 | vld_s2 | vld_s3 | (|sq_busy) | bin_vld_q;

endmodule

/* rtl/core/pdh_hist.sv */
// Histogram memory with saturating add-two updates, host reads and a
// clearing sweep after reset and on request. Depends on pdh_pkg.
module pdh_hist #(
	parameter int BINS  = 512,
	parameter int BIN_W = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pdh_pkg::hist_ctrl_t  ctrl,
	input  logic [BIN_W-1:0]     rd_addr,
	input  logic                 inc_vld,
	input  logic [BIN_W-1:0]     inc_bin,
	output logic [31:0]          rd_data,
	output pdh_pkg::hist_stat_t  stat
);
	import pdh_pkg::*;

	logic [31:0]      hist_mem [BINS];
	logic [31:0]      rd_q;
	logic             clr_act_q;
	logic [BIN_W-1:0] clr_addr_q;
	logic             wb_vld_s1;
	logic [BIN_W-1:0] wb_bin_s1;
	logic             fw_vld_q;
	logic [BIN_W-1:0] fw_bin_q;
	logic [31:0]      fw_data_q;
	logic [BIN_W-1:0] raddr;
	logic [31:0]      old_cnt;
	logic [31:0]      new_cnt;

	assign raddr = ctrl.rd_en ? rd_addr : inc_bin;

	// A write in the previous cycle is not yet visible in the read data.
	assign old_cnt = (fw_vld_q && fw_bin_q == wb_bin_s1) ? fw_data_q : rd_q;
	assign new_cnt = (old_cnt > 32'hFFFF_FFFD) ? COUNT_SAT : old_cnt + 32'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_act_q  <= 1'b1;
			clr_addr_q <= '0;
			wb_vld_s1  <= 1'b0;
			fw_vld_q   <= 1'b0;
		end else begin
			wb_vld_s1 <= inc_vld;
			fw_vld_q  <= wb_vld_s1;
			if (clr_act_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == BIN_W'(BINS - 1)) begin
					clr_act_q <= 1'b0;
				end
			end else if (ctrl.clr_start) begin
				clr_act_q  <= 1'b1;
				clr_addr_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q      <= hist_mem[raddr];
		wb_bin_s1 <= inc_bin;
		fw_bin_q  <= wb_bin_s1;
		fw_data_q <= new_cnt;
		if (clr_act_q) begin
			hist_mem[clr_addr_q] <= '0;
		end else if (wb_vld_s1) begin
			hist_mem[wb_bin_s1] <= new_cnt;
		end
	end

	assign rd_data       = rd_q;
	assign stat.clr_busy = clr_act_q;
	assign stat.wr_busy  = wb_vld_s1;

endmodule

/* test/testbench.sv */
// Self-checking testbench for pair_distance_histogram: random and directed atom frames,
// bin reads and clears, with results checked against an in-bench histogram predictor.
// Depends on pdh_pkg and the pair_distance_histogram RTL.
`timescale 1ns / 100ps

module testbench;
	import pdh_pkg::*;

	localparam int MAX_ATOMS  = 128;
	localparam int BINS       = 512;
	localparam int CYCLE_CAP  = 1_000_000;
	localparam int DRAIN_WAIT = 200;

	// The one kind code that the block ignores.
	localparam logic [1:0] KIND_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_beat;
	logic out_valid;
	logic out_ready;
	out_t out_beat;

	pair_distance_histogram #(.MAX_ATOMS(MAX_ATOMS), .BINS(BINS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_beat(in_beat),
		.out_valid(out_valid), .out_ready(out_ready), .out_beat(out_beat)
	);

	// Predictor state.
	logic [15:0] pred_x [MAX_ATOMS];
	logic [15:0] pred_y [MAX_ATOMS];
	logic [15:0] pred_z [MAX_ATOMS];
	int unsigned pred_fill;
	logic [31:0] pred_hist [BINS];
	logic [31:0] pred_frames;

	in_t  pending_beats [$];
	out_t expected_reads [$];
	int   mismatches;
	int   cycle_count;
	bit   stimulus_done;
	bit   quiet_tail;
	int   in_gap;
	int   out_stall;

	always #2 clk = ~clk;

	function automatic logic [31:0] axis_square(logic [15:0] a, logic [15:0] b);
		logic [15:0] d;
		logic [16:0] mag;
		d = a - b;
		mag = d[15] ? (17'h10000 - {1'b0, d}) : {1'b0, d};
		return mag * mag;
	endfunction

	function automatic logic [31:0] root_floor(logic [31:0] v);
		logic [31:0] res;
		logic [31:0] bitv;
		res = 0;
		bitv = 32'h4000_0000;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	task automatic tally_pair(logic [15:0] x, logic [15:0] y, logic [15:0] z, int k);
		logic [33:0] d2;
		logic [63:0] slot;
		d2 = axis_square(x, pred_x[k]) + axis_square(y, pred_y[k])
		   + axis_square(z, pred_z[k]);
		if (d2 >= 34'h4000_0000) return;
		slot = (64'(root_floor(d2[31:0])) * 2 * BINS) >> 16;
		if (slot >= BINS) return;
		if (pred_hist[slot] > 32'hFFFF_FFFD) pred_hist[slot] = COUNT_SAT;
		else pred_hist[slot] = pred_hist[slot] + 2;
	endtask

	task automatic predict_histogram(in_t b);
		out_t r;
		if (b.kind == KIND_ADD) begin
			for (int k = 0; k < pred_fill; k++) tally_pair(b.pos_x, b.pos_y, b.pos_z, k);
			if (pred_fill < MAX_ATOMS) begin
				pred_x[pred_fill] = b.pos_x;
				pred_y[pred_fill] = b.pos_y;
				pred_z[pred_fill] = b.pos_z;
				pred_fill++;
			end
			if (b.frame_end) begin
				if (pred_frames != COUNT_SAT) pred_frames++;
				pred_fill = 0;
			end
		end else if (b.kind == KIND_READ) begin
			r.bin_count = (b.bin_index < BINS) ? pred_hist[b.bin_index] : 32'd0;
			r.frames_seen = pred_frames;
			expected_reads.push_back(r);
		end else if (b.kind == KIND_CLEAR) begin
			foreach (pred_hist[i]) pred_hist[i] = 0;
			pred_frames = 0;
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
		mismatches++;
	endtask

	function automatic in_t random_noise_bits(in_t b);
		// Unused fields carry random bits so every input bit toggles.
		b.pos_x = b.kind == KIND_ADD ? b.pos_x : 16'($urandom);
		b.pos_y = b.kind == KIND_ADD ? b.pos_y : 16'($urandom);
		b.pos_z = b.kind == KIND_ADD ? b.pos_z : 16'($urandom);
		return b;
	endfunction

	function automatic in_t make_atom(logic [15:0] x, logic [15:0] y, logic [15:0] z,
			logic last);
		in_t b;
		b.kind = KIND_ADD;
		b.pos_x = x;
		b.pos_y = y;
		b.pos_z = z;
		b.frame_end = last;
		b.bin_index = 9'($urandom);
		return b;
	endfunction

	function automatic in_t make_op(logic [1:0] k, logic [8:0] idx);
		in_t b;
		b.kind = k;
		b.pos_x = 0;
		b.pos_y = 0;
		b.pos_z = 0;
		b.frame_end = 1'($urandom);
		b.bin_index = idx;
		return random_noise_bits(b);
	endfunction

	// Driver: inputs change only at rising edges.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_histogram(in_beat);
				void'(pending_beats.pop_front());
			end
			if (in_valid && !in_ready) begin
				// Hold the beat until accepted.
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_beats.size() > (in_valid && in_ready ? 0 : 0)) begin
				if (!quiet_tail && $urandom_range(0, 5) == 0) begin
					in_gap <= $urandom_range(0, 7);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_beat <= pending_beats[0];
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor and receiver stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_reads.size() == 0) begin
					report_mismatch("unexpected read result", out_beat.bin_count, 0);
				end else begin
					if (out_beat.bin_count !== expected_reads[0].bin_count)
						report_mismatch("bin_count", out_beat.bin_count,
							expected_reads[0].bin_count);
					if (out_beat.frames_seen !== expected_reads[0].frames_seen)
						report_mismatch("frames_seen", out_beat.frames_seen,
							expected_reads[0].frames_seen);
					void'(expected_reads.pop_front());
				end
			end
			if (out_stall > 0) begin
				out_stall <= out_stall - 1;
				out_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				out_stall <= $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("pair_distance_histogram regression: fail");
			$finish;
		end
	end

	task automatic queue_random_frame(int atoms, bit clustered);
		logic [15:0] cx, cy, cz;
		int spread;
		cx = 16'($urandom);
		cy = 16'($urandom);
		cz = 16'($urandom);
		spread = $urandom_range(16, 12000);
		for (int i = 0; i < atoms; i++) begin
			if (clustered)
				pending_beats.push_back(make_atom(cx + 16'($urandom_range(0, spread)),
					cy - 16'($urandom_range(0, spread)), cz + 16'($urandom_range(0, spread)),
					i == atoms - 1));
			else
				pending_beats.push_back(make_atom(16'($urandom), 16'($urandom),
					16'($urandom), i == atoms - 1));
		end
	endtask

	initial begin
		int issued;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_beat = '0;
		out_ready = 1'b0;
		mismatches = 0;
		cycle_count = 0;
		stimulus_done = 0;
		quiet_tail = 0;
		pred_fill = 0;
		pred_frames = 0;
		foreach (pred_hist[i]) pred_hist[i] = 0;

		// Directed: extremes, wrap-around, half-box cutoff, all kinds.
		pending_beats.push_back(make_op(KIND_READ, 9'd0));
		pending_beats.push_back(make_atom(16'h0000, 16'h0000, 16'h0000, 1'b0));
		pending_beats.push_back(make_atom(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		pending_beats.push_back(make_atom(16'h8000, 16'h0000, 16'h0000, 1'b0));
		pending_beats.push_back(make_atom(16'h7FFF, 16'h0000, 16'h0000, 1'b0));
		pending_beats.push_back(make_atom(16'h4000, 16'h4000, 16'h4000, 1'b1));
		pending_beats.push_back(make_op(KIND_READ, 9'd0));
		pending_beats.push_back(make_op(KIND_READ, 9'd1));
		pending_beats.push_back(make_op(KIND_READ, 9'd511));
		pending_beats.push_back(make_op(KIND_SPARE, 9'd0));
		pending_beats.push_back(make_op(KIND_READ, 9'd0));
		pending_beats.push_back(make_atom(16'h1234, 16'hAAAA, 16'h5555, 1'b0));
		pending_beats.push_back(make_op(KIND_CLEAR, 9'd0));
		pending_beats.push_back(make_op(KIND_READ, 9'd0));
		// Clear keeps the stored atom, so this pair still counts.
		pending_beats.push_back(make_atom(16'h1236, 16'hAAAA, 16'h5555, 1'b1));
		pending_beats.push_back(make_op(KIND_READ, 9'd0));

		// A frame overflowing the store exercises the full-store case.
		queue_random_frame(MAX_ATOMS + 3, 1'b1);
		for (int b = 0; b < 6; b++) pending_beats.push_back(make_op(KIND_READ, 9'($urandom)));

		issued = 0;
		while (issued < 225) begin
			int pick;
			pick = $urandom_range(0, 19);
			if (pick < 12) begin
				int n;
				n = $urandom_range(1, 12);
				queue_random_frame(n, $urandom_range(0, 3) != 0);
				issued += n;
			end else if (pick < 18) begin
				pending_beats.push_back(make_op(KIND_READ, $urandom_range(0, 3) == 0 ?
					9'($urandom) : 9'($urandom_range(0, 40))));
				issued++;
			end else if (pick == 18) begin
				pending_beats.push_back(make_op(KIND_CLEAR, 9'($urandom)));
				issued++;
			end else begin
				pending_beats.push_back(make_op(KIND_SPARE, 9'($urandom)));
				issued++;
			end
		end
		for (int b = 0; b < 20; b++)
			pending_beats.push_back(make_op(KIND_READ, 9'($urandom_range(0, 40))));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_beats.size() < 40);
		quiet_tail = 1;
		wait (pending_beats.size() == 0);
		wait (expected_reads.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && expected_reads.size() == 0) begin
			$display("pair_distance_histogram regression: pass");
		end else begin
			$display("pair_distance_histogram regression: fail");
		end
		$finish;
	end

endmodule

/* pair_distance_histogram.f */
rtl/core/pdh_pkg.sv
rtl/core/pdh_cell.sv
rtl/core/pdh_pair.sv
rtl/core/pdh_hist.sv
rtl/core/pair_distance_histogram.sv
test/testbench.sv
